[hw/rtl/float_almost_equal_compare_unit_assert.svh]
// assertion macros used by the compare unit checker
`ifndef FLOAT_ALMOST_EQUAL_COMPARE_UNIT_ASSERT_SVH
`define FLOAT_ALMOST_EQUAL_COMPARE_UNIT_ASSERT_SVH

// same-cycle implication, quiet during reset
`define FAEC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define FAEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/faec_pkg.sv]
// shared types, codes and helper functions for the almost-equal compare unit
package faec_pkg;

  localparam int unsigned WW = 56;  // working word: 53-bit significand and 3 extra bits

  localparam logic CFG_DOUBLE_MODE = 1'b0;
  localparam logic CFG_MAX_ULP     = 1'b1;

  localparam logic [2:0] DEC_REJECT = 3'd0;
  localparam logic [2:0] DEC_SAME   = 3'd1;
  localparam logic [2:0] DEC_EPS    = 3'd2;
  localparam logic [2:0] DEC_ULP    = 3'd3;
  localparam logic [2:0] DEC_NONE   = 3'd4;

  localparam logic [10:0] SGL_THR_EXP0 = 11'd104;  // bias 127 minus 23
  localparam logic [10:0] DBL_THR_EXP0 = 11'd971;  // bias 1023 minus 52

  // outcome known before the arithmetic
  typedef struct packed {
    logic       early;
    logic       early_eq;
    logic [2:0] early_code;
    logic       ulp_ok;
    logic       dbl;
  } pass_t;

  typedef struct packed {
    pass_t       pass;
    logic [52:0] sig_big;
    logic [52:0] sig_small;
    logic [10:0] exp_big;
    logic [10:0] shamt;
  } front_t;

  typedef struct packed {
    logic [WW-1:0] norm;
    logic [10:0]   exp_res;
  } norm_t;

  function automatic logic [5:0] lead_zeros(input logic [WW-1:0] v);
    logic [5:0] z;
    z = 6'd0;
    for (int i = 0; i < WW; i++) begin
      if (v[i]) z = 6'(WW - 1 - i);
    end
    return z;
  endfunction

  // magnitude bits of max_ulp * epsilon in the selected format
  function automatic logic [62:0] thr_bits(input logic [15:0] u, input logic dbl);
    logic [3:0]  k;
    logic [15:0] un;
    logic [62:0] r;
    k = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (u[i]) k = 4'(i);
    end
    un = u << (4'd15 - k);
    if (u == 16'd0) begin
      r = '0;
    end else if (dbl) begin
      r = {DBL_THR_EXP0 + {7'd0, k}, un[14:0], 37'd0};
    end else begin
      r = {32'd0, 8'(SGL_THR_EXP0 + {7'd0, k}), un[14:0], 8'd0};
    end
    return r;
  endfunction

endpackage

[hw/rtl/float_almost_equal_compare_unit.sv]
// throughput: one compare per cycle while the output side keeps up
// five registered stages, each with its own valid
// a bubble anywhere lets new beats in while a finished result waits on out_ready
// reset (rst_n low, synchronous): all stage valids clear, double_mode 0, max_ulp 4
// cfg_ready is always high; a write takes effect on the next cycle
module float_almost_equal_compare_unit import faec_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_first_value,
  input  logic [63:0] in_second_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_almost_equal,
  output logic [2:0]  out_decided_by
);

  // configuration registers
  logic        double_mode_r;
  logic [15:0] max_ulp_r;

  // stage valids: a input, b classified, c subtracted, d normalised, out result
  logic v_a_r, v_b_r, v_c_r, v_d_r, v_o_r;
  logic en_a, en_b, en_c, en_d, en_o;

  // stage payloads
  logic [63:0]   a_first_r, a_second_r;
  front_t        b_r;
  pass_t         c_pass_r;
  logic [WW-1:0] c_diff_r;
  logic [10:0]   c_exp_r;
  pass_t         d_pass_r;
  norm_t         d_norm_r;
  logic          eq_r;
  logic [2:0]    dec_r;

  // combinational stage logic
  front_t        fr;
  norm_t         nr;
  logic [WW-1:0] big_w, small_w, small_sh, lost_mask;
  logic          sticky;
  logic [WW-1:0] diff_w;
  logic [10:0]   exp_fld;
  logic          lsb, grd, stk, inc;
  logic [62:0]   pk, thr;
  logic          eps_ok;
  logic          eq_nxt;
  logic [2:0]    dec_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      double_mode_r <= 1'b0;
      max_ulp_r <= 16'd4;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DOUBLE_MODE: double_mode_r <= cfg_data[0];
        CFG_MAX_ULP:     max_ulp_r <= cfg_data;
        default:         ;
      endcase
    end
  end

  // each stage loads when empty or when the stage after it moves
  assign en_o = !v_o_r || out_ready;
  assign en_d = !v_d_r || en_o;
  assign en_c = !v_c_r || en_d;
  assign en_b = !v_b_r || en_c;
  assign en_a = !v_a_r || en_b;
  assign in_ready = en_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
      v_o_r <= 1'b0;
    end else begin
      if (en_a) v_a_r <= in_valid;
      if (en_b) v_b_r <= v_a_r;
      if (en_c) v_c_r <= v_b_r;
      if (en_d) v_d_r <= v_c_r;
      if (en_o) v_o_r <= v_d_r;
    end
  end

  // stage a: input beat
  always_ff @(posedge clk) begin
    if (en_a) begin
      a_first_r <= in_first_value;
      a_second_r <= in_second_value;
    end
  end

  // stage b: classify, order by magnitude, ulp distance
  faec_front u_front (
    .dbl     (double_mode_r),
    .max_ulp (max_ulp_r),
    .a       (a_first_r),
    .b       (a_second_r),
    .fr      (fr)
  );

  always_ff @(posedge clk) begin
    if (en_b) b_r <= fr;
  end

  // stage c: align the smaller operand with a sticky bit and subtract
  always_comb begin
    big_w = {b_r.sig_big, 3'd0};
    small_w = {b_r.sig_small, 3'd0};
    lost_mask = (56'd1 << b_r.shamt[5:0]) - 56'd1;
    if (b_r.shamt > 11'(WW - 1)) begin
      small_sh = '0;
      sticky = |small_w;
    end else begin
      small_sh = small_w >> b_r.shamt[5:0];
      sticky = |(small_w & lost_mask);
    end
    diff_w = big_w - (small_sh | {{(WW - 1){1'b0}}, sticky});
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_pass_r <= b_r.pass;
      c_diff_r <= diff_w;
      c_exp_r <= b_r.exp_big;
    end
  end

  // stage d: normalise
  faec_norm u_norm (
    .diff    (c_diff_r),
    .exp_big (c_exp_r),
    .nr      (nr)
  );

  always_ff @(posedge clk) begin
    if (en_d) begin
      d_pass_r <= c_pass_r;
      d_norm_r <= nr;
    end
  end

  // result stage: round to nearest even, compare with the epsilon threshold
  always_comb begin
    exp_fld = d_norm_r.norm[WW-1] ? d_norm_r.exp_res : 11'd0;  // hidden bit gone: subnormal
    if (d_pass_r.dbl) begin
      lsb = d_norm_r.norm[3];
      grd = d_norm_r.norm[2];
      stk = |d_norm_r.norm[1:0];
    end else begin
      lsb = d_norm_r.norm[32];
      grd = d_norm_r.norm[31];
      stk = |d_norm_r.norm[30:0];
    end
    inc = grd && (stk || lsb);
    // rounding carry ripples into the exponent field
    if (d_pass_r.dbl) begin
      pk = {exp_fld, d_norm_r.norm[54:3]} + {62'd0, inc};
    end else begin
      pk = {32'd0, exp_fld[7:0], d_norm_r.norm[54:32]} + {62'd0, inc};
    end
    thr = thr_bits(max_ulp_r, d_pass_r.dbl);
    eps_ok = (pk <= thr);

    if (d_pass_r.early) begin
      eq_nxt = d_pass_r.early_eq;
      dec_nxt = d_pass_r.early_code;
    end else if (eps_ok) begin
      eq_nxt = 1'b1;
      dec_nxt = DEC_EPS;
    end else if (d_pass_r.ulp_ok) begin
      eq_nxt = 1'b1;
      dec_nxt = DEC_ULP;
    end else begin
      eq_nxt = 1'b0;
      dec_nxt = DEC_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      eq_r <= eq_nxt;
      dec_r <= dec_nxt;
    end
  end

  assign out_valid = v_o_r;
  assign out_almost_equal = eq_r;
  assign out_decided_by = dec_r;

endmodule

[hw/rtl/faec_front.sv]
// operand classification, ordering and ulp distance
module faec_front import faec_pkg::*; (
  input  logic        dbl,
  input  logic [15:0] max_ulp,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output front_t      fr
);

  logic [62:0] ma, mb, ulp_dist;
  logic [63:0] dab;
  logic        a_big, nan_inf, both_zero, sign_diff, same;
  logic [10:0] ea_f, eb_f, ea, eb;
  logic [51:0] fa, fb;
  logic [52:0] sa, sb;

  always_comb begin
    ma = dbl ? a[62:0] : {32'd0, a[30:0]};
    mb = dbl ? b[62:0] : {32'd0, b[30:0]};
    ea_f = dbl ? a[62:52] : {3'd0, a[30:23]};
    eb_f = dbl ? b[62:52] : {3'd0, b[30:23]};
    fa = dbl ? a[51:0] : {a[22:0], 29'd0};
    fb = dbl ? b[51:0] : {b[22:0], 29'd0};
    nan_inf = dbl ? (ea_f == 11'h7FF || eb_f == 11'h7FF)
                  : (ea_f == 11'h0FF || eb_f == 11'h0FF);
    both_zero = (ma == 63'd0) && (mb == 63'd0);
    sign_diff = dbl ? (a[63] ^ b[63]) : (a[31] ^ b[31]);
    same = dbl ? (a == b) : (a[31:0] == b[31:0]);

    dab = {1'b0, ma} - {1'b0, mb};
    a_big = !dab[63];
    ulp_dist = a_big ? dab[62:0] : (mb - ma);

    // subnormals share the lowest exponent
    ea = (ea_f == 11'd0) ? 11'd1 : ea_f;
    eb = (eb_f == 11'd0) ? 11'd1 : eb_f;
    sa = {ea_f != 11'd0, fa};
    sb = {eb_f != 11'd0, fb};

    fr.pass.dbl = dbl;
    fr.pass.ulp_ok = (ulp_dist[62:16] == 47'd0) && (ulp_dist[15:0] <= max_ulp);
    fr.pass.early = 1'b1;
    fr.pass.early_eq = 1'b0;
    fr.pass.early_code = DEC_REJECT;
    if (nan_inf) begin
      fr.pass.early_code = DEC_REJECT;
    end else if (both_zero) begin
      fr.pass.early_eq = 1'b1;
      fr.pass.early_code = DEC_SAME;
    end else if (sign_diff) begin
      fr.pass.early_code = DEC_REJECT;
    end else if (same) begin
      fr.pass.early_eq = 1'b1;
      fr.pass.early_code = DEC_SAME;
    end else begin
      fr.pass.early = 1'b0;
    end

    fr.sig_big = a_big ? sa : sb;
    fr.sig_small = a_big ? sb : sa;
    fr.exp_big = a_big ? ea : eb;
    fr.shamt = a_big ? (ea - eb) : (eb - ea);
  end

endmodule

[hw/rtl/faec_norm.sv]
// leading-zero count and normalising shift, floored at the subnormal exponent
module faec_norm import faec_pkg::*; (
  input  logic [WW-1:0] diff,
  input  logic [10:0]   exp_big,
  output norm_t         nr
);

  logic [5:0]  z, sh;
  logic [10:0] em1;

  always_comb begin
    z = lead_zeros(diff);
    em1 = exp_big - 11'd1;
    sh = ({5'd0, z} <= em1) ? z : em1[5:0];
    nr.norm = diff << sh;
    nr.exp_res = exp_big - {5'd0, sh};
  end

endmodule

[hw/rtl/faec_checker.sv]
// port-level checks on the result channel, bound to the top level
module faec_checker import faec_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_almost_equal,
  input logic [2:0] out_decided_by
);

`include "float_almost_equal_compare_unit_assert.svh"

  logic [3:0] res_bits;
  logic       stalled, pass_code, fail_code;

  assign res_bits  = {out_almost_equal, out_decided_by};
  assign stalled   = out_valid && !out_ready;
  assign pass_code = (out_decided_by == DEC_SAME) || (out_decided_by == DEC_EPS) ||
                     (out_decided_by == DEC_ULP);
  assign fail_code = (out_decided_by == DEC_REJECT) || (out_decided_by == DEC_NONE);

  `FAEC_ASSERT_NEXT(a_out_hold, stalled, out_valid, "result beat dropped")
  `FAEC_ASSERT_NEXT(a_out_stable, stalled, $stable(res_bits), "stalled result changed")
  `FAEC_ASSERT_NOW(a_eq_code, out_valid && out_almost_equal, pass_code, "equal, rejecting code")
  `FAEC_ASSERT_NOW(a_ne_code, out_valid && !out_almost_equal, fail_code, "unequal, passing code")

endmodule

bind float_almost_equal_compare_unit faec_checker u_faec_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 100ps
// self-checking testbench for the float almost-equal compare unit
module tb_top import faec_pkg::*; ();

  // clock and reset
  logic        clk;
  logic        rst_n;

  // configuration write channel
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  // compare request channel
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_first_value;
  logic [63:0] in_second_value;

  // verdict channel
  logic        out_valid;
  logic        out_ready;
  logic        out_almost_equal;
  logic [2:0]  out_decided_by;

  // one verdict as the unit reports it
  typedef struct packed {
    logic       eq;
    logic [2:0] by;
  } verdict_t;

  // directed row: settings to apply, the pair, and an optional hand-typed verdict
  typedef struct packed {
    logic        dbl;
    logic [15:0] ulp;
    logic [63:0] a;
    logic [63:0] b;
    logic        typed;
    logic        eq;
    logic [2:0]  by;
  } pair_row_t;

  verdict_t    pending_verdicts[$];
  logic        shadow_dbl;
  logic [15:0] shadow_ulp;

  int unsigned mismatches;
  int unsigned verdicts_seen;
  int unsigned pairs_sent;
  int unsigned cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_req;
  int unsigned by_count[5];

  pair_row_t   directed[24];

  float_almost_equal_compare_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_first_value  (in_first_value),
    .in_second_value (in_second_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_almost_equal(out_almost_equal),
    .out_decided_by  (out_decided_by)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // magnitude of a single-precision value in units of the smallest subnormal, exact
  function automatic logic [299:0] sgl_units(input logic [30:0] m);
    if (m[30:23] == 8'd0) begin
      return 300'(m[22:0]);
    end
    return 300'({1'b1, m[22:0]}) << (m[30:23] - 8'd1);
  endfunction

  // expected verdict for a pair under the shadow settings
  function automatic verdict_t judge_pair(input logic [63:0] a, input logic [63:0] b);
    verdict_t    v;
    logic [62:0] ma, mb, ulp_dist;
    logic        sa, sb, is_special, eps_ok;
    logic [299:0] ua, ub, diff_units, lim_units;
    int          k;
    real         fa, fb, diff_r;
    v = '{eq: 1'b0, by: DEC_REJECT};
    if (shadow_dbl) begin
      ma = a[62:0];
      mb = b[62:0];
      sa = a[63];
      sb = b[63];
      is_special = (ma[62:52] == 11'h7FF) || (mb[62:52] == 11'h7FF);
    end else begin
      ma = {32'd0, a[30:0]};
      mb = {32'd0, b[30:0]};
      sa = a[31];
      sb = b[31];
      is_special = (ma[30:23] == 8'hFF) || (mb[30:23] == 8'hFF);
    end
    if (is_special) return v;
    if (ma == 63'd0 && mb == 63'd0) return '{eq: 1'b1, by: DEC_SAME};
    if (sa != sb) return v;
    if (ma == mb) return '{eq: 1'b1, by: DEC_SAME};

    if (shadow_dbl) begin
      // host doubles round to nearest even, subnormals included
      fa = $bitstoreal(a);
      fb = $bitstoreal(b);
      diff_r = fa - fb;
      if (diff_r < 0.0) diff_r = -diff_r;
      eps_ok = diff_r <= real'(shadow_ulp) * (2.0 ** -52);
    end else begin
      // exact difference, then compare against the rounding midpoint above the limit
      ua = sgl_units(ma[30:0]);
      ub = sgl_units(mb[30:0]);
      diff_units = (ua >= ub) ? ua - ub : ub - ua;
      if (shadow_ulp == 16'd0) begin
        eps_ok = diff_units == '0;
      end else begin
        k = 0;
        for (int i = 0; i < 16; i++) begin
          if (shadow_ulp[i]) k = i;
        end
        // limit is ulp * 2^-23, even mantissa, so a tie rounds down onto it
        lim_units = (300'(shadow_ulp) << 126) + (300'(1) << (102 + k));
        eps_ok = diff_units <= lim_units;
      end
    end
    if (eps_ok) return '{eq: 1'b1, by: DEC_EPS};
    ulp_dist = (ma >= mb) ? ma - mb : mb - ma;
    if (ulp_dist <= 63'(shadow_ulp)) return '{eq: 1'b1, by: DEC_ULP};
    return '{eq: 1'b0, by: DEC_NONE};
  endfunction

  // register write beat, only called while the unit is idle
  task automatic write_reg(input logic idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_DOUBLE_MODE) shadow_dbl = data[0];
    else shadow_ulp = data;
  endtask

  // drain every outstanding verdict, settle, then load both registers
  task automatic load_settings(input logic dbl, input logic [15:0] ulp);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    write_reg(CFG_DOUBLE_MODE, {15'd0, dbl});
    write_reg(CFG_MAX_ULP, ulp);
    cfg_valid <= 1'b0;
  endtask

  // offer one pair, with random idle cycles ahead of it
  task automatic send_pair(input logic [63:0] a, input logic [63:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_first_value  <= a;
    in_second_value <= b;
    do @(posedge clk); while (!in_ready);
    pending_verdicts.push_back(judge_pair(a, b));
    pairs_sent++;
  endtask

  // random finite-ish value with an exponent near the epsilon threshold
  function automatic logic [63:0] near_threshold_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (shadow_dbl) v[62:52] = 11'($urandom_range(940, 1040));
    else v[30:23] = 8'($urandom_range(90, 140));
    return v;
  endfunction

  // special encoding: nan, infinity or zero with random sign and upper bits
  function automatic logic [63:0] special_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 2))
      0: begin
        if (shadow_dbl) v[62:0] = {11'h7FF, 52'd0};
        else v[30:0] = {8'hFF, 23'd0};
      end
      1: begin
        if (shadow_dbl) v[62:52] = 11'h7FF;
        else v[30:23] = 8'hFF;
      end
      default: begin
        if (shadow_dbl) v[62:0] = '0;
        else v[30:0] = '0;
      end
    endcase
    return v;
  endfunction

  // one random pair, mostly same-sign neighbours so the arithmetic tests matter
  task automatic random_pair();
    logic [63:0] a, b;
    logic [63:0] delta;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    if (sel >= 15) begin
      if (sel < 80) a = near_threshold_value();
      if (sel < 50) delta = 64'($urandom_range(0, 2 * shadow_ulp + 3));
      else if (sel < 80) delta = 64'($urandom_range(0, 1 << 20));
      else delta = 64'($urandom_range(0, 3));
      if ($urandom_range(0, 1)) delta = -delta;
      b = {$urandom, $urandom};
      if (shadow_dbl) b[63:0] = {a[63], a[62:0] + delta[62:0]};
      else b[31:0] = {a[31], a[30:0] + delta[30:0]};
      if ($urandom_range(0, 9) == 0) begin
        if (shadow_dbl) b[63] = ~b[63];
        else b[31] = ~b[31];
      end
      if (sel >= 90) begin
        if ($urandom_range(0, 1)) a = special_value();
        else b = special_value();
        if ($urandom_range(0, 3) == 0) a = special_value();
      end
    end
    send_pair(a, b);
  endtask

  // receiver: random back-pressure, plus a long hold-off on request
  initial begin : recv_side
    int unsigned hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = 300;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // verdict checker against the oldest expectation
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      verdicts_seen++;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected verdict eq=%0b by=%0d", out_almost_equal, out_decided_by);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_decided_by <= DEC_NONE) by_count[out_decided_by]++;
        if (want.eq !== out_almost_equal || want.by !== out_decided_by) begin
          mismatches++;
          if (mismatches <= 10)
            $display("verdict mismatch: expected eq=%0b by=%0d, got eq=%0b by=%0d",
                     want.eq, want.by, out_almost_equal, out_decided_by);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top failed");
      $finish;
    end
  end

  // directed pairs: extremes, specials and every decision path
  initial begin
    directed = '{
      // single precision at reset settings
      '{1'b0, 16'd4, 64'h0000_0000_7FC0_0000, 64'h0000_0000_3F80_0000, 1'b1, 1'b0, DEC_REJECT},
      '{1'b0, 16'd4, 64'h0000_0000_7F80_0000, 64'h0000_0000_7F80_0000, 1'b1, 1'b0, DEC_REJECT},
      '{1'b0, 16'd4, 64'h0000_0000_0000_0000, 64'hFFFF_FFFF_8000_0000, 1'b1, 1'b1, DEC_SAME},
      '{1'b0, 16'd4, 64'h0000_0000_0000_0000, 64'h0000_0000_8000_0001, 1'b1, 1'b0, DEC_REJECT},
      '{1'b0, 16'd4, 64'hFFFF_FFFF_3F80_0000, 64'h0000_0000_3F80_0000, 1'b1, 1'b1, DEC_SAME},
      '{1'b0, 16'd4, 64'h0000_0000_3F80_0000, 64'h0000_0000_BF80_0000, 1'b1, 1'b0, DEC_REJECT},
      '{1'b0, 16'd4, 64'h0000_0000_3F80_0000, 64'h0000_0000_3F80_0001, 1'b0, 1'b0, DEC_REJECT},
      '{1'b0, 16'd4, 64'h0000_0000_447A_0000, 64'h0000_0000_447A_0003, 1'b0, 1'b0, DEC_REJECT},
      '{1'b0, 16'd4, 64'h0000_0000_3F80_0000, 64'h0000_0000_4000_0000, 1'b0, 1'b0, DEC_REJECT},
      '{1'b0, 16'd4, 64'h0000_0000_0000_0001, 64'h0000_0000_0000_0005, 1'b0, 1'b0, DEC_REJECT},
      '{1'b0, 16'd4, 64'h0000_0000_7F7F_FFFF, 64'h0000_0000_7F7F_FFFE, 1'b0, 1'b0, DEC_REJECT},
      // zero tolerance and widest tolerance
      '{1'b0, 16'd0, 64'h0000_0000_3F80_0000, 64'h0000_0000_3F80_0001, 1'b0, 1'b0, DEC_REJECT},
      '{1'b0, 16'd0, 64'h0000_0000_3F80_0000, 64'h1234_5678_3F80_0000, 1'b1, 1'b1, DEC_SAME},
      '{1'b0, 16'hFFFF, 64'h0000_0000_3F80_0000, 64'h0000_0000_3F81_0000, 1'b0, 1'b0, DEC_REJECT},
      '{1'b0, 16'hFFFF, 64'h0000_0000_7F7F_FFFF, 64'h0000_0000_7F7F_0000, 1'b0, 1'b0, DEC_REJECT},
      // double precision
      '{1'b1, 16'd4, 64'h7FF8_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b1, 1'b0, DEC_REJECT},
      '{1'b1, 16'd4, 64'hFFF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 1'b1, 1'b0, DEC_REJECT},
      '{1'b1, 16'd4, 64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b1, 1'b1, DEC_SAME},
      '{1'b1, 16'd4, 64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000, 1'b1, 1'b0, DEC_REJECT},
      '{1'b1, 16'd4, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0001, 1'b0, 1'b0, DEC_REJECT},
      '{1'b1, 16'd4, 64'h7E37_E43C_8800_759C, 64'h7E37_E43C_8800_759F, 1'b0, 1'b0, DEC_REJECT},
      '{1'b1, 16'd4, 64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFE, 1'b0, 1'b0, DEC_REJECT},
      '{1'b1, 16'd4, 64'h0000_0000_0000_0001, 64'h0000_0000_0000_0003, 1'b0, 1'b0, DEC_REJECT},
      '{1'b1, 16'd0, 64'h3FF0_0000_0000_0000, 64'h4000_0000_0000_0000, 1'b0, 1'b0, DEC_REJECT}
    };
  end

  // main sequence
  initial begin : main_seq
    logic        dbl;
    logic [15:0] ulp;
    verdict_t    typed_verdict;
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_DOUBLE_MODE;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_first_value  = '0;
    in_second_value = '0;
    shadow_dbl      = 1'b0;
    shadow_ulp      = 16'd4;
    mismatches      = 0;
    verdicts_seen   = 0;
    pairs_sent      = 0;
    cycles          = 0;
    send_idle_pct   = 26;
    recv_idle_pct   = 26;
    hold_req        = 1'b0;
    by_count        = '{default: 0};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part: settings change only between drained rows
    foreach (directed[i]) begin
      if (directed[i].dbl != shadow_dbl || directed[i].ulp != shadow_ulp) begin
        in_valid <= 1'b0;
        load_settings(directed[i].dbl, directed[i].ulp);
      end
      send_pair(directed[i].a, directed[i].b);
      // hand-typed verdict replaces the predicted one where given
      if (directed[i].typed) begin
        typed_verdict = '{eq: directed[i].eq, by: directed[i].by};
        pending_verdicts[pending_verdicts.size() - 1] = typed_verdict;
      end
    end

    // random phases, extremes of both registers first
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin dbl = 1'b0; ulp = 16'd0;     end
        1: begin dbl = 1'b1; ulp = 16'hFFFF;  end
        2: begin dbl = 1'b0; ulp = 16'hFFFF;  end
        3: begin dbl = 1'b1; ulp = 16'd0;     end
        4: begin dbl = 1'b0; ulp = 16'd1;     end
        5: begin dbl = 1'b1; ulp = 16'd4;     end
        default: begin
          dbl = 1'($urandom_range(0, 1));
          ulp = 16'($urandom_range(0, 40));
        end
      endcase
      in_valid <= 1'b0;
      load_settings(dbl, ulp);
      // one phase runs flat out on both sides
      send_idle_pct = (phase == 3) ? 0 : 26;
      recv_idle_pct = (phase == 3) ? 0 : 26;
      // receiver stalls long enough for the pipeline to back up
      if (phase == 5) hold_req = 1'b1;
      for (int n = 0; n < 93; n++) random_pair();
    end
    in_valid <= 1'b0;

    // drain, then let the pipeline settle
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d pairs compared over single and double precision, tolerance 0 to 65535",
             pairs_sent);
    $display("decisions: reject %0d, same %0d, epsilon %0d, ulp %0d, none %0d",
             by_count[0], by_count[1], by_count[2], by_count[3], by_count[4]);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

[float_almost_equal_compare_unit.f]
+incdir+hw/rtl
hw/rtl/faec_pkg.sv
hw/rtl/faec_front.sv
hw/rtl/faec_norm.sv
hw/rtl/float_almost_equal_compare_unit.sv
hw/rtl/faec_checker.sv
tb/tb_top.sv
